// ===== hdl/u2b_pkg.sv =====
// ----------------------------------------------------------------------------
// UTF-8 table decoder package
// Shared constants and types for the UTF-8 to single-byte decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package u2b_pkg;

  // Configuration port geometry
  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 16;

  // Configuration register indexes
  localparam logic [CfgAddrW-1:0] CFG_PASS_THROUGH  = 3'd0;
  localparam logic [CfgAddrW-1:0] CFG_FIRST_SPECIAL = 3'd1;
  localparam logic [CfgAddrW-1:0] CFG_FIRST_MAPPED  = 3'd2;
  localparam logic [CfgAddrW-1:0] CFG_UNDEF_BYTE    = 3'd3;
  localparam logic [CfgAddrW-1:0] CFG_TABLE_ENTRIES = 3'd4;

  // Item actions
  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_DECODE = 1'b1;

  // Field widths
  localparam int CodeW  = 16;
  localparam int ByteW  = 8;
  localparam int CountW = 9;

  // Table write request
  typedef struct packed {
    logic             en;
    logic [CodeW-1:0] code;
    logic [ByteW-1:0] ent_byte;
  } u2b_wr_t;

  // Table read data
  typedef struct packed {
    logic [CodeW-1:0] code;
    logic [ByteW-1:0] ent_byte;
  } u2b_rd_t;

endpackage : u2b_pkg

`default_nettype wire

// ===== hdl/u2b_table.sv =====
// ----------------------------------------------------------------------------
// UTF-8 table decoder mapping table
// One write port and one registered read port over code and byte entries.
// ----------------------------------------------------------------------------
`default_nettype none

module u2b_table
  import u2b_pkg::*;
#(
  parameter int TABLE_DEPTH = 256,
  parameter int AW          = 8
) (
  input  wire logic          clk,
  input  wire u2b_wr_t       wr,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output u2b_rd_t            rd_data
);

  u2b_rd_t mem [TABLE_DEPTH];

  // Write one entry
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_addr] <= '{code: wr.code, ent_byte: wr.ent_byte};
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule : u2b_table

`default_nettype wire

// ===== hdl/utf8_to_byte_table_decoder.sv =====
// ----------------------------------------------------------------------------
// UTF-8 to single-byte table decoder
// Loads write the table, and pass-through and direct characters go straight to the registered
//   result; a table lookup runs through the start, search and emit states before its result.
// Throughput: one item per cycle outside lookups while the output is not stalled; a lookup
//   holds the input while the binary search steps one table read per cycle.
// Reset (synchronous, rst_n low) clears the sequence state, the output and
//   the configuration registers; table contents are undefined until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_to_byte_table_decoder
  import u2b_pkg::*;
#(
  parameter int TABLE_DEPTH = 256
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // Input items
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire logic [39:0]         in_tdata,  // byte_in, entry_index, entry_code, entry_byte
  input  wire logic                in_tuser,  // action
  input  wire logic                in_tlast,  // last_byte
  // Result items
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output logic [7:0]               out_tdata, // out_byte
  output logic                     out_tuser, // is_error
  output logic                     out_tlast, // is_last
  // Configuration writes
  input  wire logic                cfg_wr_en,
  input  wire logic [CfgAddrW-1:0] cfg_addr,
  input  wire logic [CfgDataW-1:0] cfg_wdata
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int NW = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_START  = 2'd1;
  localparam logic [1:0] ST_SEARCH = 2'd2;
  localparam logic [1:0] ST_EMIT   = 2'd3;

  localparam logic [ByteW-1:0] LEAD_LIMIT = 8'h7F;
  localparam logic [ByteW-1:0] CONT_MIN   = 8'd128;

  // Input fields
  logic [ByteW-1:0] byte_in;
  logic [ByteW-1:0] entry_index;
  logic [CodeW-1:0] entry_code;
  logic [ByteW-1:0] entry_byte;

  assign byte_in     = in_tdata[7:0];
  assign entry_index = in_tdata[15:8];
  assign entry_code  = in_tdata[31:16];
  assign entry_byte  = in_tdata[39:32];

  // Configuration registers
  logic              pass_r;
  logic [ByteW-1:0]  first_special_r;
  logic [CodeW-1:0]  first_mapped_r;
  logic [ByteW-1:0]  undef_byte_r;
  logic [CountW-1:0] entries_r;

  // Control and datapath registers
  logic [1:0]       state_r, state_nxt;
  logic [CodeW-1:0] partial_r, partial_nxt;
  logic [1:0]       pend_r, pend_nxt;
  logic [CodeW-1:0] cp_r, cp_nxt;
  logic             last_r, last_nxt;
  logic [NW-1:0]    lo_r, lo_nxt;
  logic [NW-1:0]    hi_r, hi_nxt;
  logic [AW-1:0]    mid_r, mid_nxt;
  logic [ByteW-1:0] res_r, res_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [ByteW-1:0] out_byte_r, out_byte_nxt;
  logic             out_err_r, out_err_nxt;
  logic             out_last_r, out_last_nxt;

  logic       in_acc;
  logic       out_free;
  logic       rd_en;
  u2b_wr_t    tbl_wr;
  logic [AW-1:0] wr_addr;
  u2b_rd_t    rd_data;

  logic [31:0]   idx_ext;
  logic [31:0]   cnt_ext;
  logic [31:0]   cnt_clamp;
  logic [NW-1:0] n_ent;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && out_free;
  assign in_acc    = in_tvalid && in_tready;

  // Clamp the entry count to the table depth
  assign cnt_ext   = {{(32-CountW){1'b0}}, entries_r};
  assign cnt_clamp = (cnt_ext > TABLE_DEPTH) ? TABLE_DEPTH : cnt_ext;
  assign n_ent     = cnt_clamp[NW-1:0];

  // Table load path
  assign idx_ext       = {{(32-ByteW){1'b0}}, entry_index};
  assign wr_addr       = idx_ext[AW-1:0];
  assign tbl_wr.en     = in_acc && (in_tuser == ACT_LOAD) && (idx_ext < TABLE_DEPTH);
  assign tbl_wr.code   = entry_code;
  assign tbl_wr.ent_byte = entry_byte;

  u2b_table #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .AW         (AW)
  ) u_table (
    .clk    (clk),
    .wr     (tbl_wr),
    .wr_addr(wr_addr),
    .rd_en  (rd_en),
    .rd_addr(mid_nxt),
    .rd_data(rd_data)
  );

  // Decode, sequence and search control
  always_comb begin
    logic             emit;
    logic             err;
    logic [ByteW-1:0] val;
    logic             need_map;
    logic [CodeW-1:0] map_cp;
    logic [CodeW-1:0] sum_cp;
    logic [NW-1:0]    n_m1;
    logic [NW-1:0]    mid_p1;
    logic [NW-1:0]    lo_s, hi_s;
    logic [NW:0]      span;
    logic             hit, gt;

    state_nxt     = state_r;
    partial_nxt   = partial_r;
    pend_nxt      = pend_r;
    cp_nxt        = cp_r;
    last_nxt      = last_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    res_nxt       = res_r;
    rd_en         = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    out_byte_nxt  = out_byte_r;
    out_err_nxt   = out_err_r;
    out_last_nxt  = out_last_r;

    emit     = 1'b0;
    err      = 1'b0;
    val      = '0;
    need_map = 1'b0;
    map_cp   = '0;
    sum_cp   = '0;
    n_m1     = n_ent - NW'(1);
    mid_p1   = NW'(mid_r) + NW'(1);
    hit      = (rd_data.code == cp_r);
    gt       = (cp_r > rd_data.code);
    lo_s     = gt ? mid_p1 : lo_r;
    hi_s     = gt ? hi_r : NW'(mid_r);
    span     = {1'b0, lo_s} + {1'b0, hi_s} - (NW+1)'(1);

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_tuser == ACT_DECODE)) begin
          last_nxt = in_tlast;
          if (pass_r) begin
            // copy the byte and drop any partial sequence
            pend_nxt    = '0;
            partial_nxt = '0;
            emit        = 1'b1;
            val         = byte_in;
          end else if (pend_r != 2'd0) begin
            if (byte_in < CONT_MIN) begin
              pend_nxt    = '0;
              partial_nxt = '0;
              emit        = 1'b1;
              err         = 1'b1;
            end else begin
              if (pend_r == 2'd2) begin
                sum_cp = partial_r + {4'd0, byte_in[5:0], 6'd0};
              end else begin
                sum_cp = partial_r + {10'd0, byte_in[5:0]};
              end
              pend_nxt    = pend_r - 2'd1;
              partial_nxt = sum_cp;
              if (pend_r == 2'd1) begin
                partial_nxt = '0;
                need_map    = 1'b1;
                map_cp      = sum_cp;
              end else if (in_tlast) begin
                pend_nxt    = '0;
                partial_nxt = '0;
                emit        = 1'b1;
                err         = 1'b1;
              end
            end
          end else if (byte_in < first_special_r) begin
            emit = 1'b1;
            val  = byte_in;
          end else if (byte_in < LEAD_LIMIT) begin
            need_map = 1'b1;
            map_cp   = {8'd0, byte_in};
          end else if (byte_in[7:5] == 3'b110 || byte_in[7:4] == 4'b1110) begin
            // start a two- or three-byte sequence; cut off at string end
            if (in_tlast) begin
              emit = 1'b1;
              err  = 1'b1;
            end else if (byte_in[7:5] == 3'b110) begin
              partial_nxt = {5'd0, byte_in[4:0], 6'd0};
              pend_nxt    = 2'd1;
            end else begin
              partial_nxt = {byte_in[3:0], 12'd0};
              pend_nxt    = 2'd2;
            end
          end else begin
            emit = 1'b1;
            err  = 1'b1;
          end

          // direct code points skip the table
          if (need_map) begin
            if (map_cp < first_mapped_r) begin
              emit = 1'b1;
              val  = map_cp[ByteW-1:0];
            end else begin
              cp_nxt    = map_cp;
              state_nxt = ST_START;
            end
          end

          if (emit) begin
            out_valid_nxt = 1'b1;
            out_byte_nxt  = err ? '0 : val;
            out_err_nxt   = err;
            out_last_nxt  = in_tlast;
          end
        end
      end

      ST_START: begin
        // open the search window over the valid entries
        lo_nxt = '0;
        hi_nxt = n_ent;
        if (n_ent == '0) begin
          res_nxt   = undef_byte_r;
          state_nxt = ST_EMIT;
        end else begin
          mid_nxt   = AW'(n_m1 >> 1);
          rd_en     = 1'b1;
          state_nxt = ST_SEARCH;
        end
      end

      ST_SEARCH: begin
        // compare the probed entry and halve the window
        if (hit) begin
          res_nxt   = rd_data.ent_byte;
          state_nxt = ST_EMIT;
        end else if (lo_s >= hi_s) begin
          res_nxt   = undef_byte_r;
          state_nxt = ST_EMIT;
        end else begin
          lo_nxt  = lo_s;
          hi_nxt  = hi_s;
          mid_nxt = AW'(span >> 1);
          rd_en   = 1'b1;
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = res_r;
          out_err_nxt   = 1'b0;
          out_last_nxt  = last_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_r      <= '0;
      partial_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      partial_r   <= partial_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cp_r       <= cp_nxt;
    last_r     <= last_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    mid_r      <= mid_nxt;
    res_r      <= res_nxt;
    out_byte_r <= out_byte_nxt;
    out_err_r  <= out_err_nxt;
    out_last_r <= out_last_nxt;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pass_r          <= 1'b0;
      first_special_r <= 8'd128;
      first_mapped_r  <= 16'd128;
      undef_byte_r    <= 8'd63;
      entries_r       <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        CFG_PASS_THROUGH:  pass_r          <= cfg_wdata[0];
        CFG_FIRST_SPECIAL: first_special_r <= cfg_wdata[ByteW-1:0];
        CFG_FIRST_MAPPED:  first_mapped_r  <= cfg_wdata;
        CFG_UNDEF_BYTE:    undef_byte_r    <= cfg_wdata[ByteW-1:0];
        CFG_TABLE_ENTRIES: entries_r       <= cfg_wdata[CountW-1:0];
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = out_err_r;
  assign out_tlast  = out_last_r;

  // Checks
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (state_r == ST_IDLE))
    else $error("input ready outside idle");

  a_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEARCH) |-> (lo_r < hi_r) && (NW'(mid_r) >= lo_r) && (NW'(mid_r) < hi_r))
    else $error("search probe outside window");

  a_pending: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd3)
    else $error("bad pending count");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_err_r) |-> (out_byte_r == '0))
    else $error("error result carries data");

endmodule : utf8_to_byte_table_decoder

`default_nettype wire

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// UTF-8 table decoder testbench
// Streams table loads and UTF-8 strings into the decoder under random
// backpressure. A local predictor tracks the sequence state, the lookup
// table and the registers, and every result item is checked in order.
// ----------------------------------------------------------------------------
module tb;
  import u2b_pkg::*;

  // Byte values with a fixed meaning in the decode rules
  localparam logic [7:0] LEAD_DEL = 8'h7F;
  localparam logic [7:0] CONT_MIN = 8'h80;
  localparam int         DEPTH    = 256;
  localparam int         DRAIN    = 20;

  typedef struct {
    logic        act;
    logic [7:0]  b;
    logic        fin;
    logic [7:0]  idx;
    logic [15:0] code;
    logic [7:0]  tbyte;
  } stream_item_t;

  typedef struct packed {
    logic [7:0] chr;
    logic       err;
    logic       fin;
  } decoded_t;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [39:0]         in_tdata   = '0;  // byte_in, entry_index, entry_code, entry_byte
  logic                in_tuser   = 1'b0; // action
  logic                in_tlast   = 1'b0; // last_byte
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [7:0]          out_tdata;         // out_byte
  logic                out_tuser;         // is_error
  logic                out_tlast;         // is_last
  logic                cfg_wr_en  = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr   = '0;
  logic [CfgDataW-1:0] cfg_wdata  = '0;

  utf8_to_byte_table_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // Predictor state: registers, lookup table and partial sequence
  logic        cf_pass    = 1'b0;
  logic [7:0]  cf_special = 8'd128;
  logic [15:0] cf_mapped  = 16'd128;
  logic [7:0]  cf_undef   = 8'd63;
  logic [8:0]  cf_count   = 9'd0;
  logic [15:0] tab_code [DEPTH];
  logic [7:0]  tab_byte [DEPTH];
  logic [15:0] seq_code   = '0;
  logic [1:0]  seq_left   = '0;

  // Table contents as planned by the stimulus, used to aim at hits
  logic [15:0] plan_code [DEPTH];

  stream_item_t pend_q[$];
  decoded_t     decoded_q[$];
  stream_item_t cur_item;
  decoded_t     want;
  int           queued  = 0;
  int           err_cnt = 0;
  logic         no_gaps = 1'b0;

  initial begin
    forever #10 clk = ~clk;
  end

  // Binary search over the loaded slots, as the block does it
  function automatic logic [7:0] lookup_code(logic [15:0] cp);
    int lo, hi, mid, n;
    if (cp < cf_mapped) return cp[7:0];
    n  = (cf_count > 9'd256) ? DEPTH : int'(cf_count);
    lo = 0;
    hi = n - 1;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (tab_code[mid] == cp) return tab_byte[mid];
      if (cp > tab_code[mid]) lo = mid + 1;
      else hi = mid - 1;
    end
    return cf_undef;
  endfunction

  function automatic void queue_result(logic [7:0] chr, logic err, logic fin);
    decoded_t r;
    r.chr = err ? 8'h00 : chr;
    r.err = err;
    r.fin = fin;
    decoded_q.push_back(r);
  endfunction

  function automatic void clear_seq();
    seq_left = '0;
    seq_code = '0;
  endfunction

  // Advance the predictor by one accepted item
  function automatic void predict_item(stream_item_t it);
    logic [15:0] cp;
    if (it.act == ACT_LOAD) begin
      tab_code[it.idx] = it.code;
      tab_byte[it.idx] = it.tbyte;
      return;
    end
    if (cf_pass) begin
      clear_seq();
      queue_result(it.b, 1'b0, it.fin);
      return;
    end
    // Continuation position
    if (seq_left != 0) begin
      if (it.b < CONT_MIN) begin
        clear_seq();
        queue_result(8'h00, 1'b1, it.fin);
        return;
      end
      if (seq_left == 2) seq_code = seq_code + {4'b0, it.b[5:0], 6'b0};
      else seq_code = seq_code + {10'b0, it.b[5:0]};
      seq_left = seq_left - 2'd1;
      if (seq_left == 0) begin
        cp = seq_code;
        seq_code = '0;
        queue_result(lookup_code(cp), 1'b0, it.fin);
      end else if (it.fin) begin
        clear_seq();
        queue_result(8'h00, 1'b1, it.fin);
      end
      return;
    end
    // Lead position
    if (it.b < cf_special) begin
      queue_result(it.b, 1'b0, it.fin);
      return;
    end
    if (it.b < LEAD_DEL) begin
      queue_result(lookup_code({8'h00, it.b}), 1'b0, it.fin);
      return;
    end
    if (it.b[7:5] == 3'b110) begin
      seq_code = {5'b0, it.b[4:0], 6'b0};
      seq_left = 2'd1;
    end else if (it.b[7:4] == 4'b1110) begin
      seq_code = {it.b[3:0], 12'b0};
      seq_left = 2'd2;
    end else begin
      queue_result(8'h00, 1'b1, it.fin);
      return;
    end
    if (it.fin) begin
      clear_seq();
      queue_result(8'h00, 1'b1, it.fin);
    end
  endfunction

  // Driver: present queued items, predict each one as it is accepted
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) predict_item(cur_item);
      if (!in_tvalid || in_tready) begin
        if (pend_q.size() != 0 && (no_gaps || $urandom_range(99) >= 28)) begin
          cur_item = pend_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {cur_item.tbyte, cur_item.code, cur_item.idx, cur_item.b};
          in_tuser  <= cur_item.act;
          in_tlast  <= cur_item.fin;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result item with the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (decoded_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, got byte %02h err %0b last %0b",
                   $time, out_tdata, out_tuser, out_tlast);
          err_cnt++;
        end else begin
          want = decoded_q.pop_front();
          if (out_tdata !== want.chr) begin
            $display("%0t: out_byte expected %02h got %02h", $time, want.chr, out_tdata);
            err_cnt++;
          end
          if (out_tuser !== want.err) begin
            $display("%0t: is_error expected %0b got %0b", $time, want.err, out_tuser);
            err_cnt++;
          end
          if (out_tlast !== want.fin) begin
            $display("%0t: is_last expected %0b got %0b", $time, want.fin, out_tlast);
            err_cnt++;
          end
        end
      end
      out_tready <= no_gaps || ($urandom_range(99) >= 28);
    end
  end

  task automatic push_byte(logic [7:0] b, logic fin);
    stream_item_t it;
    it.act   = ACT_DECODE;
    it.b     = b;
    it.fin   = fin;
    it.idx   = 8'($urandom);
    it.code  = 16'($urandom);
    it.tbyte = 8'($urandom);
    pend_q.push_back(it);
    queued++;
  endtask

  task automatic push_load(logic [7:0] idx, logic [15:0] code, logic [7:0] tbyte);
    stream_item_t it;
    it.act   = ACT_LOAD;
    it.b     = 8'($urandom);
    it.fin   = 1'($urandom);
    it.idx   = idx;
    it.code  = code;
    it.tbyte = tbyte;
    plan_code[idx] = code;
    pend_q.push_back(it);
    queued++;
  endtask

  function automatic logic [7:0] cont_bits(logic [5:0] v);
    return {1'b1, 1'($urandom), v};
  endfunction

  // Build one string of mostly well-formed characters, with some noise
  task automatic queue_string();
    logic [7:0]  str_q[$];
    logic [15:0] cp;
    int          nchar, kind;
    nchar = $urandom_range(6, 1);
    repeat (nchar) begin
      kind = $urandom_range(99);
      if (kind < 25) begin
        // plain byte below the special range
        if (cf_special == 0) str_q.push_back(8'($urandom));
        else str_q.push_back(8'($urandom_range(int'(cf_special) - 1)));
      end else if (kind < 35) begin
        // single special byte that goes through the code mapping
        if (cf_special <= 8'h7E) str_q.push_back(8'($urandom_range(8'h7E, int'(cf_special))));
        else str_q.push_back(8'($urandom));
      end else if (kind < 60) begin
        // two-byte character
        cp = $urandom_range(1) ? plan_code[$urandom_range(127)] : 16'($urandom_range(2047));
        if (cp > 16'd2047) cp = 16'($urandom_range(2047));
        str_q.push_back({3'b110, cp[10:6]});
        str_q.push_back(cont_bits(cp[5:0]));
      end else if (kind < 85) begin
        // three-byte character
        cp = $urandom_range(1) ? plan_code[$urandom_range(DEPTH - 1)] : 16'($urandom);
        str_q.push_back({4'b1110, cp[15:12]});
        str_q.push_back(cont_bits(cp[11:6]));
        str_q.push_back(cont_bits(cp[5:0]));
      end else if (kind < 90) begin
        // bad lead byte
        case ($urandom_range(2))
          0: str_q.push_back(LEAD_DEL);
          1: str_q.push_back({2'b10, 6'($urandom)});
          default: str_q.push_back({4'b1111, 4'($urandom)});
        endcase
      end else if (kind < 95) begin
        // sequence broken by a low byte in continuation position
        if ($urandom_range(1)) begin
          str_q.push_back({3'b110, 5'($urandom)});
        end else begin
          str_q.push_back({4'b1110, 4'($urandom)});
          if ($urandom_range(1)) str_q.push_back(cont_bits(6'($urandom)));
        end
        str_q.push_back({1'b0, 7'($urandom)});
      end else begin
        str_q.push_back(8'($urandom));
      end
    end
    // cut the string off in the middle of a sequence now and then
    if ($urandom_range(99) < 12) begin
      if ($urandom_range(1)) begin
        str_q.push_back({3'b110, 5'($urandom)});
      end else begin
        str_q.push_back({4'b1110, 4'($urandom)});
        if ($urandom_range(1)) str_q.push_back(cont_bits(6'($urandom)));
      end
    end
    foreach (str_q[i]) begin
      if ($urandom_range(99) < 3) push_load(8'($urandom), 16'($urandom), 8'($urandom));
      push_byte(str_q[i], i == str_q.size() - 1);
    end
  endtask

  // Hold until every item is taken and every result is back
  task automatic wait_drained();
    while (pend_q.size() != 0 || in_tvalid || decoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgAddrW-1:0] a, logic [15:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= a;
    cfg_wdata <= v;
    case (a)
      CFG_PASS_THROUGH:  cf_pass    = v[0];
      CFG_FIRST_SPECIAL: cf_special = v[7:0];
      CFG_FIRST_MAPPED:  cf_mapped  = v;
      CFG_UNDEF_BYTE:    cf_undef   = v[7:0];
      CFG_TABLE_ENTRIES: cf_count   = v[8:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic pass, logic [7:0] special, logic [15:0] mapped,
                            logic [7:0] undef, logic [8:0] count);
    write_reg(CFG_PASS_THROUGH, {15'b0, pass});
    write_reg(CFG_FIRST_SPECIAL, {8'b0, special});
    write_reg(CFG_FIRST_MAPPED, mapped);
    write_reg(CFG_UNDEF_BYTE, {8'b0, undef});
    write_reg(CFG_TABLE_ENTRIES, {7'b0, count});
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_strings(int n);
    queued = 0;
    while (queued < n) queue_string();
  endtask

  // Run watchdog
  initial begin
    #(20 * 400000);
    $display("tb: errors");
    $finish;
  end

  // Main sequence
  initial begin
    int i, c;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings, empty table: every lookup misses
    push_byte(8'h00, 1'b0);
    push_byte(8'h41, 1'b1);
    push_byte(8'h80, 1'b0);
    push_byte(8'hFF, 1'b1);
    push_byte(8'hC3, 1'b0);
    push_byte(8'hA9, 1'b0);
    push_byte(8'hC1, 1'b0);
    push_byte(8'h81, 1'b1);
    push_byte(8'hC2, 1'b1);
    push_byte(8'hE2, 1'b0);
    push_byte(8'h82, 1'b1);
    push_byte(8'hE2, 1'b0);
    push_byte(8'h41, 1'b1);

    // Fill every slot with ascending codes spread over the whole range
    for (i = 0; i < DEPTH; i++) begin
      if (i < 64) c = i * 2 + $urandom_range(1);
      else if (i < 128) c = 128 + (i - 64) * 30 + $urandom_range(29);
      else c = 2048 + (i - 128) * 496 + $urandom_range(495);
      push_load(8'(i), 16'(c), 8'($urandom));
    end
    wait_drained();

    // Full table, low special threshold
    set_config(1'b0, 8'h20, 16'h0040, 8'hA5, 9'd256);
    push_byte(8'h1F, 1'b0);
    push_byte(8'h20, 1'b0);
    push_byte(8'h7E, 1'b0);
    push_byte(LEAD_DEL, 1'b1);
    push_byte(8'hC0, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'hEF, 1'b0);
    push_byte(8'hBF, 1'b0);
    push_byte(8'hBF, 1'b1);
    push_byte({4'b1110, plan_code[200][15:12]}, 1'b0);
    push_byte(cont_bits(plan_code[200][11:6]), 1'b0);
    push_byte(cont_bits(plan_code[200][5:0]), 1'b1);
    run_strings(330);
    // leave a sequence open across the switch to copy mode
    push_byte(8'hE2, 1'b0);
    wait_drained();

    // Copy mode
    set_config(1'b1, 8'h80, 16'h0080, 8'h3F, 9'd256);
    run_strings(150);
    wait_drained();

    // Everything mapped, count above the table size
    set_config(1'b0, 8'h00, 16'h0000, 8'h00, 9'h1FF);
    run_strings(300);
    push_byte(8'hE2, 1'b0);
    push_byte(8'h82, 1'b0);
    wait_drained();

    // Everything direct, one-slot table; finish the open sequence first
    set_config(1'b0, 8'hFF, 16'hFFFF, 8'hFF, 9'd1);
    push_byte(8'hBF, 1'b1);
    run_strings(250);
    wait_drained();

    // Back-to-back traffic, partial table
    no_gaps = 1'b1;
    set_config(1'b0, 8'h80, 16'h0080, 8'h3F, 9'd200);
    run_strings(300);
    wait_drained();
    no_gaps = 1'b0;

    // High special threshold, lookups above the two-byte range
    set_config(1'b0, 8'hC0, 16'h0800, 8'h5A, 9'd256);
    run_strings(200);
    wait_drained();

    if (err_cnt == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// ===== utf8_to_byte_table_decoder.f =====
hdl/u2b_pkg.sv
hdl/u2b_table.sv
hdl/utf8_to_byte_table_decoder.sv
tb/sv/tb.sv
